### src/ptab_pkg.sv
// Shared types and constants for the peer table.
package ptab_pkg;
	localparam int Entries = 16;
	localparam int IdxW = $clog2(Entries);
	localparam int CntW = $clog2(Entries + 1);
	localparam logic [31:0] TimeoutReset = 32'd3000;

	typedef enum logic [3:0] {
		OP_CLEAR = 4'd0,
		OP_ADD = 4'd1,
		OP_REMOVE = 4'd2,
		OP_FIND_MAC = 4'd3,
		OP_FIND_ROLE = 4'd4,
		OP_READ_SLOT = 4'd5,
		OP_MARK_ONLINE = 4'd6,
		OP_MARK_DATA_OK = 4'd7,
		OP_TICK = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_step;
		logic shift_step;
		logic finish;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic scan_hit;
		logic shift_last;
		logic is_shift;
		logic is_scan;
	} sts_t;
endpackage

### src/ptab_ctrl.sv
// Controller state machine for the peer table.
module ptab_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input ptab_pkg::sts_t sts,
	output ptab_pkg::cmd_t cmd,
	output logic busy
);
	import ptab_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nx = ST_SCAN;
			end
			ST_SCAN: begin
				if (!sts.is_scan || sts.scan_hit || sts.scan_last) begin
					if (sts.is_shift && sts.scan_hit) state_nx = ST_SHIFT;
					else state_nx = ST_EMIT;
				end
			end
			ST_SHIFT: begin
				if (sts.shift_last) state_nx = ST_EMIT;
			end
			ST_EMIT: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: cmd.load = start;
			ST_SCAN: begin
				cmd.scan_step = sts.is_scan && !sts.scan_hit && !sts.scan_last;
				cmd.finish = !sts.is_scan || sts.scan_hit || sts.scan_last;
			end
			ST_SHIFT: cmd.shift_step = 1'b1;
			ST_EMIT: cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
	a_emit_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !busy) else $error("emit not followed by idle");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.scan_step, cmd.shift_step, cmd.emit}))
		else $error("conflicting commands");
endmodule

### src/ptab_dp.sv
// Datapath of the peer table: entry registers, scan, shift and result.
module ptab_dp (
	input logic clk,
	input logic arst_n,
	input ptab_pkg::cmd_t cmd,
	output ptab_pkg::sts_t sts,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic [3:0] operation,
	input logic [47:0] peer_address,
	input logic [7:0] peer_role,
	input logic online_flag,
	input logic [31:0] entry_last_seen,
	input logic [31:0] entry_last_data_ok,
	input logic [3:0] slot_index,
	input logic [31:0] now_ms,
	output logic done,
	output logic found,
	output logic [3:0] slot,
	output logic [47:0] out_address,
	output logic [7:0] out_role,
	output logic out_online,
	output logic [31:0] out_last_seen,
	output logic [31:0] out_last_data_ok,
	output logic [4:0] entry_count,
	output logic [15:0] offline_mask
);
	import ptab_pkg::*;

	logic [47:0] addr_q [Entries];
	logic [7:0] role_q [Entries];
	logic online_q [Entries];
	logic [31:0] seen_q [Entries];
	logic [31:0] dok_q [Entries];
	logic [CntW-1:0] count_q;
	logic [31:0] timeout_q;

	op_t op_q;
	logic [47:0] key_q;
	logic [7:0] krole_q;
	logic kon_q;
	logic [31:0] kseen_q, kdok_q, now_q;
	logic [3:0] sidx_q;
	logic [IdxW-1:0] ptr_q;
	logic hit_q;
	logic [15:0] mask_q;

	logic [IdxW-1:0] ip1;
	logic in_range, match, is_search, stale;

	assign ip1 = ptr_q + IdxW'(1);
	assign in_range = ({1'b0, ptr_q} < count_q);
	assign is_search = (op_q == OP_ADD) || (op_q == OP_REMOVE) ||
		(op_q == OP_FIND_MAC) || (op_q == OP_FIND_ROLE) ||
		(op_q == OP_MARK_ONLINE) || (op_q == OP_MARK_DATA_OK);
	assign stale = online_q[ptr_q] && ((now_q - seen_q[ptr_q]) > timeout_q);
	always_comb begin
		if (op_q == OP_FIND_ROLE) match = in_range && (role_q[ptr_q] == krole_q);
		else match = in_range && (addr_q[ptr_q] == key_q);
	end

	assign sts.is_scan = is_search || (op_q == OP_TICK);
	assign sts.is_shift = (op_q == OP_REMOVE);
	assign sts.scan_hit = is_search && match;
	assign sts.scan_last = ({1'b0, ip1} >= count_q) || (ptr_q == IdxW'(Entries - 1));
	assign sts.shift_last = ({1'b0, ip1} >= count_q) || (ptr_q == IdxW'(Entries - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			timeout_q <= TimeoutReset;
			done <= 1'b0;
		end else begin
			if (cfg_we) timeout_q <= cfg_wdata;
			done <= cmd.emit;
			if (cmd.finish) begin
				case (op_q)
					OP_CLEAR: count_q <= '0;
					OP_ADD: if (!match && count_q < CntW'(Entries)) count_q <= count_q + 1'b1;
					default: ;
				endcase
			end
			if (cmd.shift_step && sts.shift_last) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(operation);
			key_q <= peer_address;
			krole_q <= peer_role;
			kon_q <= online_flag;
			kseen_q <= entry_last_seen;
			kdok_q <= entry_last_data_ok;
			sidx_q <= slot_index;
			now_q <= now_ms;
			ptr_q <= '0;
			hit_q <= 1'b0;
			mask_q <= '0;
		end
		if (cmd.scan_step || (cmd.finish && op_q == OP_TICK)) begin
			if (op_q == OP_TICK && in_range && stale) begin
				online_q[ptr_q] <= 1'b0;
				if (32'(ptr_q) < 16) mask_q[4'(ptr_q)] <= 1'b1;
			end
			if (cmd.scan_step) ptr_q <= ip1;
		end
		if (cmd.finish) begin
			case (op_q)
				OP_ADD: begin
					if (match || count_q < CntW'(Entries)) begin
						hit_q <= 1'b1;
						if (!match) ptr_q <= count_q[IdxW-1:0];
						addr_q[match ? ptr_q : count_q[IdxW-1:0]] <= key_q;
						role_q[match ? ptr_q : count_q[IdxW-1:0]] <= krole_q;
						online_q[match ? ptr_q : count_q[IdxW-1:0]] <= kon_q;
						seen_q[match ? ptr_q : count_q[IdxW-1:0]] <= kseen_q;
						dok_q[match ? ptr_q : count_q[IdxW-1:0]] <= kdok_q;
					end
				end
				OP_REMOVE, OP_FIND_MAC, OP_FIND_ROLE: hit_q <= match;
				OP_MARK_ONLINE: if (match) begin
					hit_q <= 1'b1;
					online_q[ptr_q] <= kon_q;
					seen_q[ptr_q] <= now_q;
				end
				OP_MARK_DATA_OK: if (match) begin
					hit_q <= 1'b1;
					dok_q[ptr_q] <= now_q;
				end
				OP_READ_SLOT: begin
					hit_q <= ({1'b0, sidx_q} < 5'(count_q)) && (32'(sidx_q) < Entries);
					ptr_q <= IdxW'(sidx_q);
				end
				default: ;
			endcase
		end
		// hold the removed entry before the shift overwrites it
		if (cmd.finish && op_q == OP_REMOVE) begin
			slot <= match ? 4'(ptr_q) : '0;
			out_address <= match ? addr_q[ptr_q] : '0;
			out_role <= match ? role_q[ptr_q] : '0;
			out_online <= match ? online_q[ptr_q] : 1'b0;
			out_last_seen <= match ? seen_q[ptr_q] : '0;
			out_last_data_ok <= match ? dok_q[ptr_q] : '0;
		end
		if (cmd.shift_step) begin
			if (!sts.shift_last) begin
				addr_q[ptr_q] <= addr_q[ip1];
				role_q[ptr_q] <= role_q[ip1];
				online_q[ptr_q] <= online_q[ip1];
				seen_q[ptr_q] <= seen_q[ip1];
				dok_q[ptr_q] <= dok_q[ip1];
				ptr_q <= ip1;
			end
		end
		if (cmd.emit) begin
			found <= hit_q || op_q == OP_CLEAR || op_q == OP_TICK;
			if (op_q != OP_REMOVE) begin
				slot <= hit_q ? 4'(ptr_q) : '0;
				out_address <= hit_q ? addr_q[ptr_q] : '0;
				out_role <= hit_q ? role_q[ptr_q] : '0;
				out_online <= hit_q ? online_q[ptr_q] : 1'b0;
				out_last_seen <= hit_q ? seen_q[ptr_q] : '0;
				out_last_data_ok <= hit_q ? dok_q[ptr_q] : '0;
			end
			entry_count <= 5'(count_q);
			offline_mask <= (op_q == OP_TICK) ? mask_q : '0;
		end
	end
endmodule

### src/peer_table_with_timeout_aging_core.sv
// Top level of the peer table with timeout aging.
// An accepted word scans the table, one slot scanned a cycle, until a hit or the last
// entry (clear and read-slot skip the scan); remove then shifts the later entries down.
// One word at a time; busy drops in the strobe cycle, so the next word
// can go at the edge ending it. The receiver cannot stall; done marks one cycle.
// Reset clears the count and sets timeout to 3000; entries are undefined.
module peer_table_with_timeout_aging_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic [3:0] operation,
	input logic [47:0] peer_address,
	input logic [7:0] peer_role,
	input logic online_flag,
	input logic [31:0] entry_last_seen,
	input logic [31:0] entry_last_data_ok,
	input logic [3:0] slot_index,
	input logic [31:0] now_ms,
	output logic done,
	output logic found,
	output logic [3:0] slot,
	output logic [47:0] out_address,
	output logic [7:0] out_role,
	output logic out_online,
	output logic [31:0] out_last_seen,
	output logic [31:0] out_last_data_ok,
	output logic [4:0] entry_count,
	output logic [15:0] offline_mask
);
	import ptab_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic busy_c;

	ptab_ctrl u_ctrl (.clk, .arst_n, .start, .sts, .cmd, .busy(busy_c));
	assign busy = busy_c;

	ptab_dp u_dp (.clk, .arst_n, .cmd, .sts, .cfg_we, .cfg_wdata, .operation,
		.peer_address, .peer_role, .online_flag, .entry_last_seen,
		.entry_last_data_ok, .slot_index, .now_ms, .done, .found, .slot,
		.out_address, .out_role, .out_online, .out_last_seen, .out_last_data_ok,
		.entry_count, .offline_mask);
endmodule

### bench/ptab_checker.sv
// Checker for the peer table: tracks accepted words, predicts results and compares them.
module ptab_checker
	import ptab_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic [3:0] operation,
	input logic [47:0] peer_address,
	input logic [7:0] peer_role,
	input logic online_flag,
	input logic [31:0] entry_last_seen,
	input logic [31:0] entry_last_data_ok,
	input logic [3:0] slot_index,
	input logic [31:0] now_ms,
	input logic done,
	input logic found,
	input logic [3:0] slot,
	input logic [47:0] out_address,
	input logic [7:0] out_role,
	input logic out_online,
	input logic [31:0] out_last_seen,
	input logic [31:0] out_last_data_ok,
	input logic [4:0] entry_count,
	input logic [15:0] offline_mask,
	output int errors,
	output int pending
);
	typedef struct packed {
		logic found;
		logic [3:0] slot;
		logic [47:0] addr;
		logic [7:0] role;
		logic online;
		logic [31:0] seen;
		logic [31:0] dok;
		logic [4:0] count;
		logic [15:0] mask;
	} peer_result_t;

	logic [47:0] addr_tab [Entries];
	logic [7:0] role_tab [Entries];
	logic online_tab [Entries];
	logic [31:0] seen_tab [Entries];
	logic [31:0] dok_tab [Entries];
	int peer_count;
	logic [31:0] timeout;
	peer_result_t expected_q [$];

	assign pending = expected_q.size();

	function automatic int lookup_addr(logic [47:0] a);
		for (int i = 0; i < peer_count; i++)
			if (addr_tab[i] == a)
				return i;
		return -1;
	endfunction

	function automatic peer_result_t entry_word(int i);
		peer_result_t r;
		r = '0;
		r.found = 1'b1;
		r.slot = i[3:0];
		r.addr = addr_tab[i];
		r.role = role_tab[i];
		r.online = online_tab[i];
		r.seen = seen_tab[i];
		r.dok = dok_tab[i];
		return r;
	endfunction

	task automatic predict_table_op(output peer_result_t r);
		int s;
		logic [31:0] age;
		r = '0;
		case (operation)
			OP_CLEAR: begin
				peer_count = 0;
				r.found = 1'b1;
			end
			OP_ADD: begin
				s = lookup_addr(peer_address);
				if (s < 0 && peer_count < Entries) begin
					s = peer_count;
					peer_count++;
				end
				if (s >= 0) begin
					addr_tab[s] = peer_address;
					role_tab[s] = peer_role;
					online_tab[s] = online_flag;
					seen_tab[s] = entry_last_seen;
					dok_tab[s] = entry_last_data_ok;
					r = entry_word(s);
				end
			end
			OP_REMOVE: begin
				s = lookup_addr(peer_address);
				if (s >= 0) begin
					r = entry_word(s);
					for (int i = s; i + 1 < peer_count; i++) begin
						addr_tab[i] = addr_tab[i + 1];
						role_tab[i] = role_tab[i + 1];
						online_tab[i] = online_tab[i + 1];
						seen_tab[i] = seen_tab[i + 1];
						dok_tab[i] = dok_tab[i + 1];
					end
					peer_count--;
				end
			end
			OP_FIND_MAC: begin
				s = lookup_addr(peer_address);
				if (s >= 0)
					r = entry_word(s);
			end
			OP_FIND_ROLE: begin
				for (int i = 0; i < peer_count; i++)
					if (role_tab[i] == peer_role) begin
						r = entry_word(i);
						break;
					end
			end
			OP_READ_SLOT: begin
				if (slot_index < peer_count)
					r = entry_word(slot_index);
			end
			OP_MARK_ONLINE: begin
				s = lookup_addr(peer_address);
				if (s >= 0) begin
					online_tab[s] = online_flag;
					seen_tab[s] = now_ms;
					r = entry_word(s);
				end
			end
			OP_MARK_DATA_OK: begin
				s = lookup_addr(peer_address);
				if (s >= 0) begin
					dok_tab[s] = now_ms;
					r = entry_word(s);
				end
			end
			OP_TICK: begin
				for (int i = 0; i < peer_count; i++) begin
					age = now_ms - seen_tab[i];
					if (online_tab[i] && age > timeout) begin
						online_tab[i] = 1'b0;
						r.mask[i] = 1'b1;
					end
				end
				r.found = 1'b1;
			end
			default: ;
		endcase
		r.count = peer_count[4:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		peer_result_t got, want;
		if (!arst_n) begin
			peer_count = 0;
			timeout = TimeoutReset;
			errors = 0;
			expected_q.delete();
		end else begin
			if (done) begin
				got = {found, slot, out_address, out_role, out_online, out_last_seen,
					out_last_data_ok, entry_count, offline_mask};
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t unexpected result word %h", $time, got);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t mismatch: expected %h actual %h", $time, want, got);
						$display("  fields f/slot/addr/role/onl/seen/dok/cnt/mask");
						$display("  exp %b %h %h %h %b %h %h %0d %h", want.found, want.slot,
							want.addr, want.role, want.online, want.seen, want.dok,
							want.count, want.mask);
						$display("  act %b %h %h %h %b %h %h %0d %h", got.found, got.slot,
							got.addr, got.role, got.online, got.seen, got.dok,
							got.count, got.mask);
					end
				end
			end
			if (cfg_we)
				timeout = cfg_wdata;
			if (start && !busy) begin
				predict_table_op(want);
				expected_q.push_back(want);
			end
		end
	end
endmodule

### bench/tb.sv
// Top of the peer table testbench: clock, reset, stimulus and verdict.
module tb;
	import ptab_pkg::*;

	localparam logic [3:0] OpUnusedLo = 4'd9;
	localparam logic [3:0] OpUnusedHi = 4'd15;
	localparam int PoolSize = 24;

	logic clk, arst_n, start, busy, cfg_we, online_flag, done, found, out_online;
	logic [31:0] cfg_wdata, entry_last_seen, entry_last_data_ok, now_ms;
	logic [31:0] out_last_seen, out_last_data_ok;
	logic [3:0] operation, slot_index, slot;
	logic [47:0] peer_address, out_address;
	logic [7:0] peer_role, out_role;
	logic [4:0] entry_count;
	logic [15:0] offline_mask;
	int errors, pending;

	logic [47:0] addr_pool [PoolSize];
	logic [7:0] role_pool [6];
	logic [31:0] clock_ms;
	logic allow_gaps;
	int sent;

	peer_table_with_timeout_aging_core dut (.*);

	ptab_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("timeout waiting for the table");
		$display("status: fail");
		$finish;
	end

	task automatic send_word(logic [3:0] op, logic [47:0] a, logic [7:0] r, logic o,
			logic [31:0] ls, logic [31:0] ld, logic [3:0] si, logic [31:0] nw);
		operation <= op;
		peer_address <= a;
		peer_role <= r;
		online_flag <= o;
		entry_last_seen <= ls;
		entry_last_data_ok <= ld;
		slot_index <= si;
		now_ms <= nw;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sent++;
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic drain_and_set_timeout(logic [31:0] value);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random_word();
		logic [3:0] op;
		logic [47:0] a;
		logic [7:0] r;
		logic [31:0] ls;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) op = OP_ADD;
		else if (pick < 42) op = OP_REMOVE;
		else if (pick < 52) op = OP_FIND_MAC;
		else if (pick < 60) op = OP_FIND_ROLE;
		else if (pick < 68) op = OP_READ_SLOT;
		else if (pick < 76) op = OP_MARK_ONLINE;
		else if (pick < 83) op = OP_MARK_DATA_OK;
		else if (pick < 95) op = OP_TICK;
		else if (pick < 97) op = OP_CLEAR;
		else op = 4'($urandom_range(OpUnusedLo, OpUnusedHi));
		a = ($urandom_range(0, 9) == 0) ? {16'($urandom), 32'($urandom)}
			: addr_pool[$urandom_range(0, PoolSize - 1)];
		r = $urandom_range(0, 1) ? role_pool[$urandom_range(0, 5)] : 8'($urandom);
		ls = ($urandom_range(0, 9) == 0) ? 32'($urandom)
			: clock_ms - 32'($urandom_range(0, 6000));
		if (op == OP_TICK)
			clock_ms = clock_ms + 32'($urandom_range(0, 2500));
		send_word(op, a, r, 1'($urandom), ls, 32'($urandom),
			4'($urandom), clock_ms);
	endtask

	initial begin
		logic [31:0] timeouts [4];
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		operation = OP_CLEAR;
		peer_address = '0;
		peer_role = '0;
		online_flag = 1'b0;
		entry_last_seen = '0;
		entry_last_data_ok = '0;
		slot_index = '0;
		now_ms = '0;
		sent = 0;
		allow_gaps = 1'b1;
		clock_ms = $urandom;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < PoolSize; i++)
			addr_pool[i] = {16'($urandom), 32'($urandom)};
		role_pool = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h2A, 8'h55};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_TICK, '0, '0, 1'b0, '0, '0, '0, 32'd0);
		send_word(OP_READ_SLOT, '0, '0, 1'b0, '0, '0, 4'd0, '0);
		for (int i = 0; i < Entries; i++)
			send_word(OP_ADD, addr_pool[i], role_pool[i % 6], 1'b1,
				(i == 1) ? 32'hFFFF_FFFF : 32'd0, (i == 1) ? 32'hFFFF_FFFF : 32'd0,
				'0, '0);
		send_word(OP_ADD, addr_pool[Entries], 8'h11, 1'b1, '0, '0, '0, '0);
		send_word(OP_ADD, addr_pool[3], 8'hFF, 1'b0, 32'd7, 32'd9, '0, '0);
		send_word(OP_READ_SLOT, '0, '0, 1'b0, '0, '0, 4'd15, '0);
		send_word(OP_FIND_MAC, addr_pool[1], '0, 1'b0, '0, '0, '0, '0);
		send_word(OP_FIND_ROLE, '0, 8'h55, 1'b0, '0, '0, '0, '0);
		send_word(OP_MARK_ONLINE, addr_pool[2], '0, 1'b1, '0, '0, '0, 32'hFFFF_FFF0);
		send_word(OP_MARK_DATA_OK, addr_pool[0], '0, 1'b0, '0, '0, '0, 32'hFFFF_FFFF);
		send_word(OP_REMOVE, addr_pool[5], '0, 1'b0, '0, '0, '0, '0);
		send_word(OP_REMOVE, addr_pool[20], '0, 1'b0, '0, '0, '0, '0);
		send_word(OP_FIND_MAC, addr_pool[5], '0, 1'b0, '0, '0, '0, '0);
		send_word(OP_FIND_ROLE, '0, 8'h77, 1'b0, '0, '0, '0, '0);
		send_word(OP_READ_SLOT, '0, '0, 1'b0, '0, '0, 4'd15, '0);
		send_word(OP_TICK, '0, '0, 1'b0, '0, '0, '0, 32'd3001);
		send_word(OpUnusedHi, '1, '1, 1'b1, '1, '1, '1, '1);
		send_word(OP_CLEAR, '0, '0, 1'b0, '0, '0, '0, '0);

		timeouts = '{32'd0, 32'hFFFF_FFFF, 32'($urandom_range(1, 4000)), TimeoutReset};
		for (int ph = 0; ph < 4; ph++) begin
			drain_and_set_timeout(timeouts[ph]);
			for (int n = 0; n < 320; n++) begin
				if (ph == 3 && n >= 170)
					allow_gaps = 1'b0;
				send_random_word();
			end
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2 * Entries + 8) @(posedge clk);
		$display("sent %0d table operations over four timeout settings (0, max, random, 3000)",
			sent);
		$display("covered fill to capacity, shifting removes, lookups, marks and wrapping ticks");
		if (errors == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
